>>> rtl/hrle_pkg.sv
// Shared types and constants for the hybrid run decoder.
package hrle_pkg;
    localparam int unsigned Chunk     = 1024;
    localparam int unsigned MaxValues = 32768;
    localparam int unsigned MaxWidth  = 24;
    localparam int unsigned QDepth    = 2;

    typedef enum logic [1:0] {
        ST_ITEM  = 2'd0,
        ST_DONE  = 2'd1,
        ST_ERROR = 2'd2
    } t_status;

    localparam logic CFG_EXPECTED = 1'b0;
    localparam logic CFG_SECTION  = 1'b1;

    // Work handed from the byte parser to the item emitter.
    typedef struct packed {
        logic        has_run;
        logic [15:0] start;
        logic [15:0] count;
        logic        bit_packed;
        logic [26:0] base;
        logic [4:0]  width;
        logic        has_end;
        t_status     end_status;
    } t_cmd;
endpackage

>>> rtl/hrle_front.sv
// Byte parser: decodes width, headers and values into run commands.
module hrle_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [23:0]  i_cfg_data,
    input  logic         i_valid,
    output logic         o_ready,
    input  logic [7:0]   i_byte,
    input  logic         i_first,
    output logic         o_cmd_valid,
    input  logic         i_cmd_ready,
    output hrle_pkg::t_cmd o_cmd
);
    import hrle_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_HEADER, PH_VALUE, PH_SKIP} t_phase;

    logic [15:0] r_expected;
    logic [23:0] r_seclen;
    t_phase      r_phase, n_phase;
    logic [4:0]  r_width, n_width;
    logic [31:0] r_hacc, n_hacc;
    logic [2:0]  r_hshift, n_hshift;
    logic [23:0] r_pos, n_pos;
    logic [15:0] r_prod, n_prod;
    logic [15:0] r_runcnt, n_runcnt;
    logic [23:0] r_rval, n_rval;
    logic [1:0]  r_vidx, n_vidx;
    logic [23:0] r_skip, n_skip;

    logic [15:0] w_exp;
    logic [15:0] w_rem;
    logic [1:0]  w_nbytes;
    t_cmd        w_cmd;
    logic        w_emit;
    logic        w_fire;

    assign w_exp    = (r_expected > 16'(MaxValues)) ? 16'(MaxValues) : r_expected;
    assign w_nbytes = 2'((6'(r_width) + 6'd7) >> 3);
    assign o_ready  = i_cmd_ready;
    assign w_fire   = i_valid && o_ready;

    always_comb begin
        logic [15:0] rem0;
        logic [15:0] prod1;
        logic [23:0] pos1;
        logic [2:0]  idx;
        logic [31:0] h;
        logic [31:0] groups;
        logic [36:0] bytes;
        logic [34:0] cnt;
        logic [23:0] rv;
        logic [1:0]  k;
        logic [4:0]  bw;
        logic        boundary;
        logic [23:0] skip1;
        n_phase = r_phase; n_width = r_width; n_hacc = r_hacc; n_hshift = r_hshift;
        n_pos = r_pos; n_prod = r_prod; n_runcnt = r_runcnt; n_rval = r_rval;
        n_vidx = r_vidx; n_skip = r_skip;
        w_cmd = '0;
        w_emit = 1'b0;
        boundary = 1'b0;
        prod1 = r_prod;
        pos1 = r_pos;
        rem0 = '0; idx = '0; h = '0; groups = '0; bytes = '0; cnt = '0;
        rv = '0; k = '0; bw = r_width; skip1 = '0;
        w_rem = (w_exp > r_prod) ? w_exp - r_prod : 16'd0;
        if (i_first) begin
            n_pos = '0; n_prod = '0; n_runcnt = '0; n_rval = '0; n_vidx = '0;
            n_skip = '0; n_hacc = '0; n_hshift = '0;
            prod1 = '0; pos1 = '0;
            if (i_byte > 8'(MaxWidth)) begin
                n_width = '0; n_phase = PH_IDLE;
                w_cmd.has_end = 1'b1; w_cmd.end_status = ST_ERROR;
            end else begin
                bw = i_byte[4:0];
                n_width = bw;
                if (w_exp == 16'd0) begin
                    n_phase = PH_IDLE;
                    w_cmd.has_end = 1'b1; w_cmd.end_status = ST_DONE;
                end else if (bw == 5'd0) begin
                    w_cmd.has_run = 1'b1; w_cmd.count = w_exp;
                    n_prod = w_exp; n_phase = PH_IDLE;
                    w_cmd.has_end = 1'b1; w_cmd.end_status = ST_DONE;
                end else begin
                    boundary = 1'b1;
                end
            end
        end else if (r_phase != PH_IDLE) begin
            if (r_pos >= r_seclen) begin
                n_phase = PH_IDLE;
                w_cmd.has_end = 1'b1; w_cmd.end_status = ST_ERROR;
            end else begin
                pos1 = r_pos + 24'd1;
                n_pos = pos1;
                case (r_phase)
                    PH_HEADER: begin
                        idx = (r_hshift > 3'd4) ? 3'd4 : r_hshift;
                        h = r_hacc | (32'(i_byte[6:0]) << (5'd7 * 5'(idx)));
                        n_hacc = h;
                        if (i_byte[7]) begin
                            if (idx >= 3'd4 || pos1 >= r_seclen) begin
                                n_phase = PH_IDLE;
                                w_cmd.has_end = 1'b1; w_cmd.end_status = ST_ERROR;
                            end else begin
                                n_hshift = idx + 3'd1;
                            end
                        end else if (h[0]) begin
                            groups = h >> 1;
                            bytes = 37'(groups) * 37'(r_width);
                            cnt = 35'(groups) << 3;
                            if (37'(pos1) + bytes > 37'(r_seclen)) begin
                                n_phase = PH_IDLE;
                                w_cmd.has_end = 1'b1; w_cmd.end_status = ST_ERROR;
                            end else begin
                                if (cnt > 35'(w_rem)) cnt = 35'(w_rem);
                                w_cmd.has_run = (cnt != '0);
                                w_cmd.start = r_prod; w_cmd.count = cnt[15:0];
                                w_cmd.bit_packed = 1'b1;
                                w_cmd.base = 27'(pos1) << 3;
                                prod1 = r_prod + cnt[15:0];
                                n_prod = prod1;
                                skip1 = bytes[23:0];
                                n_skip = skip1;
                                rem0 = (w_exp > prod1) ? w_exp - prod1 : 16'd0;
                                if (rem0 == 16'd0 || bytes == '0) boundary = 1'b1;
                                else n_phase = PH_SKIP;
                            end
                        end else begin
                            if (h[31:1] == '0 || 26'(pos1) + 26'(w_nbytes) > 26'(r_seclen)) begin
                                n_phase = PH_IDLE;
                                w_cmd.has_end = 1'b1; w_cmd.end_status = ST_ERROR;
                            end else begin
                                n_runcnt = (h[31:1] > 31'(w_rem)) ? w_rem : h[16:1];
                                n_rval = '0; n_vidx = '0; n_phase = PH_VALUE;
                            end
                        end
                    end
                    PH_VALUE: begin
                        k = (r_vidx > 2'd2) ? 2'd2 : r_vidx;
                        rv = r_rval | (24'(i_byte) << (5'd8 * 5'(k)));
                        n_rval = rv;
                        if (k + 2'd1 >= w_nbytes) begin
                            w_cmd.has_run = (r_runcnt != '0);
                            w_cmd.start = r_prod; w_cmd.count = r_runcnt;
                            w_cmd.base = 27'(rv);
                            prod1 = r_prod + r_runcnt;
                            n_prod = prod1;
                            boundary = 1'b1;
                        end else begin
                            n_vidx = k + 2'd1;
                        end
                    end
                    PH_SKIP: begin
                        skip1 = (r_skip > 24'd0) ? r_skip - 24'd1 : r_skip;
                        n_skip = skip1;
                        if (skip1 == '0) boundary = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
        w_cmd.width = bw;
        if (boundary) begin
            n_hacc = '0; n_hshift = '0;
            rem0 = (w_exp > prod1) ? w_exp - prod1 : 16'd0;
            if (rem0 == 16'd0) begin
                n_phase = PH_IDLE;
                w_cmd.has_end = 1'b1; w_cmd.end_status = ST_DONE;
            end else if (pos1 >= r_seclen) begin
                n_phase = PH_IDLE;
                w_cmd.has_end = 1'b1; w_cmd.end_status = ST_ERROR;
            end else begin
                n_phase = PH_HEADER;
            end
        end
        // A byte that yields neither values nor a closing status sends no command.
        w_emit = w_cmd.has_run || w_cmd.has_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected <= '0; r_seclen <= '0; r_phase <= PH_IDLE; r_width <= '0;
            r_hacc <= '0; r_hshift <= '0; r_pos <= '0; r_prod <= '0;
            r_runcnt <= '0; r_rval <= '0; r_vidx <= '0; r_skip <= '0;
            o_cmd_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_EXPECTED) r_expected <= i_cfg_data[15:0];
                else                           r_seclen   <= i_cfg_data;
            end
            o_cmd_valid <= (w_fire && w_emit) || (o_cmd_valid && !i_cmd_ready);
            if (w_fire) begin
                r_phase <= n_phase; r_width <= n_width; r_hacc <= n_hacc;
                r_hshift <= n_hshift; r_pos <= n_pos; r_prod <= n_prod;
                r_runcnt <= n_runcnt; r_rval <= n_rval; r_vidx <= n_vidx;
                r_skip <= n_skip;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_emit) o_cmd <= w_cmd;
    end
endmodule

>>> rtl/hrle_queue.sv
// Two-entry queue of run commands between parser and emitter.
module hrle_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hrle_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output hrle_pkg::t_cmd o_cmd
);
    import hrle_pkg::*;

    t_cmd       r_mem [QDepth];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_push, w_pop;

    assign o_ready = (r_cnt != 2'(QDepth));
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_cmd;
    end
endmodule

>>> rtl/hrle_back.sv
// Item emitter: splits each run command into chunks and closing status.
module hrle_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  hrle_pkg::t_cmd i_cmd,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [55:0]    o_data,
    output logic           o_last
);
    import hrle_pkg::*;

    logic [15:0] r_done;
    logic [26:0] r_off;
    logic        r_ovalid;
    logic [55:0] r_data;
    logic        r_last;
    logic        w_slot;
    logic        w_run_left;
    logic [15:0] w_left;
    logic [10:0] w_chunk;
    logic [26:0] w_pay;
    logic        w_run_final;

    assign w_slot      = !r_ovalid || i_ready;
    assign w_run_left  = i_cmd.has_run && (r_done < i_cmd.count);
    assign w_left      = i_cmd.count - r_done;
    assign w_chunk     = (w_left < 16'(Chunk)) ? w_left[10:0] : 11'(Chunk);
    assign w_pay       = i_cmd.bit_packed ? i_cmd.base + r_off : i_cmd.base;
    assign w_run_final = (w_left <= 16'(Chunk));
    assign o_ready     = w_slot && (w_run_left ? (w_run_final && !i_cmd.has_end) : 1'b1);
    assign o_valid     = r_ovalid;
    assign o_data      = r_data;
    assign o_last      = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0; r_done <= '0; r_off <= '0;
        end else if (w_slot) begin
            r_ovalid <= i_valid;
            if (i_valid) begin
                if (w_run_left) begin
                    if (w_run_final && !i_cmd.has_end) begin
                        r_done <= '0; r_off <= '0;
                    end else begin
                        r_done <= r_done + 16'(w_chunk);
                        r_off  <= r_off + 27'(w_chunk) * 27'(i_cmd.width);
                    end
                end else begin
                    r_done <= '0; r_off <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_slot && i_valid) begin
            if (w_run_left) begin
                r_data <= {w_pay, i_cmd.bit_packed, w_chunk,
                           i_cmd.start[14:0] + r_done[14:0], ST_ITEM};
                r_last <= w_run_final && !i_cmd.has_end;
            end else begin
                r_data <= {54'd0, i_cmd.end_status};
                r_last <= 1'b1;
            end
        end
    end
endmodule

>>> rtl/hybrid_rle_run_to_work_items.sv
// Top level of the hybrid run decoder.
// channel | dir | payload
// s_axis  | in  | tdata[7:0] data_byte, tuser first
// m_axis  | out | tdata status,value_start,count,bit_packed,payload; tlast last
// cfg     | in  | i_cfg_we, i_cfg_idx 0 expected_values / 1 section_length
// One byte per cycle enters while the command queue has room. The emitter
// splits each run into items of at most 1024 values, plus a status item when
// the run also closes the section. Synchronous active-low reset returns to
// idle; either side may stall freely.
module hybrid_rle_run_to_work_items (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tuser,   // first
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // status, value_start, count, bit_packed, payload
    output logic        m_axis_tlast    // last
);
    import hrle_pkg::*;

    logic  w_fv, w_fr, w_qv, w_qr;
    t_cmd  w_fc, w_qc;
    logic [55:0] w_data;

    hrle_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata), .i_first(s_axis_tuser),
        .o_cmd_valid(w_fv), .i_cmd_ready(w_fr), .o_cmd(w_fc)
    );
    hrle_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_cmd(w_fc),
        .o_valid(w_qv), .i_ready(w_qr), .o_cmd(w_qc)
    );
    hrle_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_cmd(w_qc),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_data(w_data), .o_last(m_axis_tlast)
    );
    assign m_axis_tdata = {8'd0, w_data};
endmodule

>>> rtl/hrle_checker.sv
// Port-level checks for the hybrid run decoder, bound to the top level.
module hrle_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    import hrle_pkg::*;

    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3) else $error("bad status");
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] != ST_ITEM |-> m_axis_tlast)
        else $error("status item not last");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == ST_ITEM |-> m_axis_tdata[27:17] != 11'd0)
        else $error("empty work item");
endmodule

bind hybrid_rle_run_to_work_items hrle_checker u_chk (
    .i_clk, .i_rst_n, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);

>>> tb/hrle_checker.sv
// Checker for the hybrid run decoder: predicts work items from accepted bytes and compares.
module hrle_scoreboard
    import hrle_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        m_axis_tlast,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_HEADER = 2'd1,
        PH_VALUE  = 2'd2,
        PH_SKIP   = 2'd3
    } t_phase;

    typedef struct packed {
        t_status     status;
        logic [14:0] value_start;
        logic [10:0] count;
        logic        bit_packed;
        logic [26:0] payload;
        logic        last;
    } t_work;

    t_work       work_q[$];
    t_work       step_q[$];
    logic [15:0] exp_vals;
    logic [23:0] sec_len;
    t_phase      phase;
    logic [4:0]  width;
    logic [31:0] hdr_acc;
    logic [2:0]  hdr_idx;
    logic [23:0] byte_pos;
    logic [15:0] produced;
    logic [15:0] run_len;
    logic [23:0] rep_val;
    logic [1:0]  val_idx;
    logic [23:0] skip_left;
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = work_q.size();

    function automatic int unsigned values_left();
        int unsigned e;
        e = (exp_vals > MaxValues) ? MaxValues : exp_vals;
        return (e > produced) ? e - produced : 0;
    endfunction

    function automatic int unsigned value_bytes();
        return (int'(width) + 7) / 8;
    endfunction

    task automatic push(t_status st, int unsigned start, int unsigned cnt, logic bp,
                        longint unsigned pay);
        t_work w;
        w.status      = st;
        w.value_start = start[14:0];
        w.count       = cnt[10:0];
        w.bit_packed  = bp;
        w.payload     = pay[26:0];
        w.last        = 1'b0;
        step_q = {step_q, w};
    endtask

    task automatic close_section(t_status st);
        push(st, 0, 0, 1'b0, 0);
        phase = PH_IDLE;
    endtask

    task automatic emit_chunks(int unsigned cnt, logic bp, longint unsigned base);
        int unsigned done;
        int unsigned piece;
        done = 0;
        while (done < cnt) begin
            piece = (cnt - done < Chunk) ? cnt - done : Chunk;
            push(ST_ITEM, produced + done, piece, bp,
                 bp ? base + longint'(done) * width : longint'(rep_val));
            done += piece;
        end
        produced = produced + cnt[15:0];
    endtask

    task automatic run_boundary();
        hdr_acc = 0;
        hdr_idx = 0;
        if (values_left() == 0) close_section(ST_DONE);
        else if (byte_pos >= sec_len) close_section(ST_ERROR);
        else phase = PH_HEADER;
    endtask

    task automatic header_complete();
        longint unsigned groups;
        longint unsigned nbytes;
        longint unsigned cnt;
        int unsigned     left;
        left = values_left();
        if (hdr_acc[0]) begin
            groups = hdr_acc >> 1;
            nbytes = groups * width;
            cnt    = groups * 8;
            if (longint'(byte_pos) + nbytes > sec_len) begin
                close_section(ST_ERROR);
                return;
            end
            if (cnt > left) cnt = left;
            emit_chunks(cnt, 1'b1, longint'(byte_pos) * 8);
            skip_left = nbytes[23:0];
            if (values_left() == 0 || nbytes == 0) run_boundary();
            else phase = PH_SKIP;
        end else begin
            cnt = hdr_acc >> 1;
            if (cnt == 0 || longint'(byte_pos) + value_bytes() > sec_len) begin
                close_section(ST_ERROR);
                return;
            end
            run_len = (cnt > left) ? left[15:0] : cnt[15:0];
            rep_val = 0;
            val_idx = 0;
            phase   = PH_VALUE;
        end
    endtask

    task automatic predict_byte(logic [7:0] b, logic first_byte);
        int unsigned k;
        int unsigned idx;
        step_q = {};
        if (first_byte) begin
            byte_pos = 0; produced = 0; run_len = 0; rep_val = 0;
            val_idx = 0; skip_left = 0; hdr_acc = 0; hdr_idx = 0;
            if (b > MaxWidth) begin
                width = 0;
                close_section(ST_ERROR);
            end else begin
                width = b[4:0];
                if (values_left() == 0) close_section(ST_DONE);
                else if (width == 0) begin
                    emit_chunks(values_left(), 1'b0, 0);
                    close_section(ST_DONE);
                end else run_boundary();
            end
        end else if (phase != PH_IDLE) begin
            if (byte_pos >= sec_len) close_section(ST_ERROR);
            else begin
                byte_pos = byte_pos + 1;
                case (phase)
                    PH_HEADER: begin
                        idx = (hdr_idx > 4) ? 4 : hdr_idx;
                        hdr_acc = hdr_acc | (32'(b[6:0]) << (7 * idx));
                        if (b[7]) begin
                            if (idx >= 4 || byte_pos >= sec_len) close_section(ST_ERROR);
                            else hdr_idx = 3'(idx + 1);
                        end else header_complete();
                    end
                    PH_VALUE: begin
                        k = (val_idx > 2) ? 2 : val_idx;
                        rep_val = rep_val | (24'(b) << (8 * k));
                        if (k + 1 >= value_bytes()) begin
                            emit_chunks(run_len, 1'b0, 0);
                            run_boundary();
                        end else val_idx = 2'(k + 1);
                    end
                    default: begin
                        if (skip_left > 0) skip_left = skip_left - 1;
                        if (skip_left == 0) run_boundary();
                    end
                endcase
            end
        end
        if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
        work_q = {work_q, step_q};
    endtask

    task automatic report(string what, t_work want, t_work got);
        fails++;
        if (fails <= 10)
            $display("%t mismatch %s: want %p, got %p", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin
        t_work got;
        t_work want;
        if (!i_rst_n) begin
            work_q = {};
            exp_vals = 0; sec_len = 0; phase = PH_IDLE; width = 0;
            hdr_acc = 0; hdr_idx = 0; byte_pos = 0; produced = 0;
            run_len = 0; rep_val = 0; val_idx = 0; skip_left = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.status      = t_status'(m_axis_tdata[1:0]);
                got.value_start = m_axis_tdata[16:2];
                got.count       = m_axis_tdata[27:17];
                got.bit_packed  = m_axis_tdata[28];
                got.payload     = m_axis_tdata[55:29];
                got.last        = m_axis_tlast;
                if (work_q.size() == 0) report("unexpected item", got, got);
                else begin
                    want = work_q.pop_front();
                    if (got != want) report("field", want, got);
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_EXPECTED) exp_vals = i_cfg_data[15:0];
                else sec_len = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) predict_byte(s_axis_tdata, s_axis_tuser);
        end
    end

    initial fails = 0;
endmodule

>>> tb/tb_hybrid_rle_run_to_work_items.sv
// Testbench top: drives page sections into the hybrid run decoder and gives the verdict.
module tb_hybrid_rle_run_to_work_items;
    import hrle_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [23:0] i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // data_byte
    logic        s_axis_tuser;   // first
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // status, value_start, count, bit_packed, payload
    logic        m_axis_tlast;   // last
    int          fail_count;
    int          pending;
    int          sent;
    bit          calm;

    hybrid_rle_run_to_work_items dut (.*);

    hrle_scoreboard checker_i (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("tb_hybrid_rle_run_to_work_items failed");
        $finish;
    end

    // Receiver stalls about a third of the time except during the calm stretch.
    always @(negedge i_clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 32);

    // The valid line stays up between back-to-back items and drops only while idling.
    task automatic send_byte(logic [7:0] b, logic first_byte);
        while (!calm && $urandom_range(99) < 32) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first_byte;
        sent++;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [23:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(negedge i_clk);
    endtask

    task automatic configure(int unsigned vals, int unsigned len);
        drain();
        write_reg(CFG_EXPECTED, 24'(vals));
        write_reg(CFG_SECTION, 24'(len));
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_uleb(int unsigned v);
        do begin
            send_byte({(v >> 7) != 0, 7'(v)}, 1'b0);
            v = v >> 7;
        end while (v != 0);
    endtask

    // One section with random runs; some bytes may be noise and the section length may run short.
    task automatic random_section();
        int unsigned w;
        int unsigned vals;
        int unsigned groups;
        int unsigned cnt;
        w    = ($urandom_range(9) == 0) ? $urandom_range(24) : $urandom_range(8, 1);
        vals = ($urandom_range(15) == 0) ? $urandom_range(3000) : $urandom_range(120);
        configure(vals, ($urandom_range(7) == 0) ? $urandom_range(12) : 60);
        send_byte(8'(w), 1'b1);
        repeat ($urandom_range(5, 1)) begin
            if ($urandom_range(1)) begin
                groups = $urandom_range(3);
                send_uleb(groups * 2 + 1);
                repeat (groups * w) send_byte(8'($urandom), 1'b0);
            end else begin
                cnt = ($urandom_range(9) == 0) ? $urandom_range(2500) : $urandom_range(40);
                send_uleb(cnt * 2);
                repeat ((w + 7) / 8) send_byte(8'($urandom), 1'b0);
            end
            if ($urandom_range(19) == 0) send_byte(8'($urandom), 1'b0);
        end
    endtask

    initial begin
        i_rst_n = 0; i_cfg_we = 0; i_cfg_idx = 0; i_cfg_data = 0;
        s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
        m_axis_tready = 0; sent = 0; calm = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;

        // Directed: extremes and error cases.
        send_byte(8'h55, 1'b0);                  // ignored while idle
        send_byte(8'd25, 1'b1);                  // width too large
        send_byte(8'd255, 1'b1);
        configure(0, 0);
        send_byte(8'd5, 1'b1);                   // nothing expected
        configure(32768, 16777215);
        send_byte(8'd0, 1'b1);                   // width zero over full range
        configure(65535, 0);
        send_byte(8'd3, 1'b1);                   // empty section
        configure(100, 16777215);
        send_byte(8'd24, 1'b1);
        send_byte(8'h00, 1'b0);                  // zero repeat count
        send_byte(8'd24, 1'b1);
        repeat (5) send_byte(8'hFF, 1'b0);       // overlong header
        send_byte(8'd24, 1'b1);
        send_uleb(60);
        send_byte(8'hAB, 1'b0); send_byte(8'hCD, 1'b0); send_byte(8'hEF, 1'b0);
        send_uleb(81);                           // bit-packed past completion
        send_byte(8'h7F, 1'b0);
        configure(20, 3);
        send_byte(8'd1, 1'b1);
        send_uleb(5);                            // two groups, payload then out of bytes
        send_byte(8'h11, 1'b0); send_byte(8'h22, 1'b0);
        send_byte(8'h80, 1'b0);

        calm = 1;
        repeat (6) random_section();
        calm = 0;
        while (sent < 330) random_section();
        configure(0, 0);
        drain();

        if (fail_count == 0 && pending == 0)
            $display("tb_hybrid_rle_run_to_work_items passed");
        else
            $display("tb_hybrid_rle_run_to_work_items failed");
        $finish;
    end
endmodule

>>> sim.f
rtl/hrle_pkg.sv
rtl/hrle_front.sv
rtl/hrle_queue.sv
rtl/hrle_back.sv
rtl/hybrid_rle_run_to_work_items.sv
rtl/hrle_checker.sv
tb/hrle_checker.sv
tb/tb_hybrid_rle_run_to_work_items.sv
